### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C register access master.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

package i2cm_pkg;

    // Input transaction as seen on the push side
    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // Result transaction as seen on the pop side
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } result_t;

    // Mode codes of an input transaction
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Classified command handed from the front queue to the engine
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_READ,
        CMD_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } cmd_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_PAUSE  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] DELAY_UNIT_RST  = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
    localparam logic [7:0]  READ_PAUSE_RST  = 8'd5;

    // Both queues are two entries deep
    localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/core/i2c_register_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Pin-level I2C master for one-byte register reads and writes.
// ----------------------------------------------------------------------------
// Each pushed transaction yields exactly one result transaction that carries
// the bus levels (scl, sda_out, sda_drive) and status after it. Mode 1 starts
// a register read, mode 2 a register write; every other transaction, and any
// request while busy, is a tick that samples sda_in and advances the bus by
// one step. The engine takes one transaction per clock, so the sustained rate
// is one transaction per cycle as long as results are popped. A result
// reaches the pop side through the input queue and result queue registers.
// Bus timing is counted in tick transactions, not clock cycles. The user must
// make configuration writes only while no transaction is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------

module i2c_register_access_master (
    input  logic                             clk,
    input  logic                             rst_n,
    // input side
    input  logic                             push,
    output logic                             full,
    input  i2cm_pkg::item_t                  item,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output i2cm_pkg::result_t                result,
    // configuration
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // front queue to engine
    logic              cmd_valid;
    logic              cmd_pop;
    i2cm_pkg::cmd_t    cmd;

    // engine to result queue
    logic              rsp_push;
    logic              rsp_full;
    i2cm_pkg::result_t rsp;

    // Front: classifies mode, buffers up to two transactions
    i2cm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Engine: bus phase sequencer, steps whenever a command waits and
    // the result queue has room
    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_full  (rsp_full),
        .rsp_push  (rsp_push),
        .rsp       (rsp)
    );

    // Result queue: decouples the engine from pop stalls
    i2cm_rsp_queue u_rsp_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .rsp_push (rsp_push),
        .rsp      (rsp),
        .rsp_full (rsp_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // A transaction that ends reports the bus idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_push && rsp.done_res) |-> !rsp.busy_res)
        else $error("done reported while still busy");

    // Released SDA always reads back as high
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_push && !rsp.sda_drive) |-> rsp.sda_out)
        else $error("sda_out low while SDA released");

    // Engine never pushes into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> !rsp_full)
        else $error("result pushed into full queue");

    // Input side can only back up behind waiting results
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input queue full with no result waiting");

endmodule

### rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input transactions, classifies the mode and queues them for the engine.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module i2cm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  i2cm_pkg::item_t item,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output i2cm_pkg::cmd_t  cmd
);

    i2cm_pkg::cmd_t mem_reg [i2cm_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;
    i2cm_pkg::cmd_t entry;

    // mode three and ticks both behave as a tick
    always_comb
    begin
        entry.dev_addr   = item.dev_addr;
        entry.reg_addr   = item.reg_addr;
        entry.write_data = item.write_data;
        entry.sda_in     = item.sda_in;
        case (item.mode)
            i2cm_pkg::MODE_READ:  entry.kind = i2cm_pkg::CMD_READ;
            i2cm_pkg::MODE_WRITE: entry.kind = i2cm_pkg::CMD_WRITE;
            default:              entry.kind = i2cm_pkg::CMD_TICK;
        endcase
    end

    assign full      = (count_reg == 2'(i2cm_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

### rtl/core/i2cm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one queued command per step, produces the pin levels after it.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module i2cm_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             cmd_valid,
    output logic                             cmd_pop,
    input  i2cm_pkg::cmd_t                   cmd,
    input  logic                             rsp_full,
    output logic                             rsp_push,
    output i2cm_pkg::result_t                rsp
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_HI, PH_ST_LO, PH_TX_SET, PH_TX_HI, PH_TX_LO,
        PH_ACK_REL, PH_ACK_HI, PH_ACK_POLL, PH_PAUSE, PH_RX_LO, PH_RX_HI,
        PH_NAK_LO, PH_NAK_HI, PH_SP_LO, PH_SP_HI
    } phase_t;

    logic [15:0] delay_unit_reg;
    logic [7:0]  ack_timeout_reg;
    logic [7:0]  read_pause_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  byte_step_reg, byte_step_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_count_reg, delay_count_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic [6:0]  dev_addr_reg, dev_addr_next;
    logic [7:0]  reg_addr_reg, reg_addr_next;
    logic [7:0]  wr_data_reg, wr_data_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        err_reg, err_next;

    logic        fire;
    logic        done;
    logic [15:0] unit;
    logic [16:0] cnt_inc;
    logic        elapsed;
    logic [3:0]  bit_inc;
    logic [7:0]  rx_shift;
    logic [7:0]  poll_inc;

    assign fire     = cmd_valid && !rsp_full;
    assign cmd_pop  = fire;
    assign rsp_push = fire;

    always_comb
    begin
        unit     = (delay_unit_reg == 16'd0) ? 16'd1 : delay_unit_reg;
        cnt_inc  = {1'b0, delay_count_reg} + 17'd1;
        elapsed  = (cnt_inc >= {1'b0, unit});
        bit_inc  = bit_index_reg + 4'd1;
        rx_shift = {shift_reg[6:0], cmd.sda_in};
        poll_inc = poll_count_reg + 8'd1;

        phase_next       = phase_reg;
        byte_step_next   = byte_step_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        poll_count_next  = poll_count_reg;
        dev_addr_next    = dev_addr_reg;
        reg_addr_next    = reg_addr_reg;
        wr_data_next     = wr_data_reg;
        is_read_next     = is_read_reg;
        last_read_next   = last_read_reg;
        err_next         = err_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd.kind != i2cm_pkg::CMD_TICK)
            begin
                dev_addr_next    = cmd.dev_addr;
                reg_addr_next    = cmd.reg_addr;
                wr_data_next     = cmd.write_data;
                is_read_next     = (cmd.kind == i2cm_pkg::CMD_READ);
                err_next         = 1'b0;
                byte_step_next   = 2'd0;
                bit_index_next   = 4'd0;
                poll_count_next  = 8'd0;
                delay_count_next = 16'd0;
                phase_next       = PH_ST_HI;
            end
        end
        else
        begin
            // timed phases: count up, wrap to zero on unit end
            delay_count_next = elapsed ? 16'd0 : cnt_inc[15:0];
            case (phase_reg)
                PH_ST_HI:
                    if (elapsed) phase_next = PH_ST_LO;
                PH_ST_LO:
                    if (elapsed)
                    begin
                        shift_next     = {dev_addr_reg, (byte_step_reg != 2'd0)};
                        bit_index_next = 4'd0;
                        phase_next     = PH_TX_SET;
                    end
                PH_TX_SET:
                    if (elapsed) phase_next = PH_TX_HI;
                PH_TX_HI:
                    if (elapsed) phase_next = PH_TX_LO;
                PH_TX_LO:
                    if (elapsed)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_inc >= 4'd8)
                        begin
                            bit_index_next = 4'd0;
                            phase_next     = PH_ACK_REL;
                        end
                        else
                        begin
                            bit_index_next = bit_inc;
                            phase_next     = PH_TX_SET;
                        end
                    end
                PH_ACK_REL:
                    if (elapsed) phase_next = PH_ACK_HI;
                PH_ACK_HI:
                    if (elapsed)
                    begin
                        poll_count_next = 8'd0;
                        phase_next      = PH_ACK_POLL;
                    end
                PH_ACK_POLL:
                begin
                    // polled every step, not timed
                    delay_count_next = 16'd0;
                    if (!cmd.sda_in)
                    begin
                        case (byte_step_reg)
                            2'd0:
                            begin
                                byte_step_next = 2'd1;
                                shift_next     = reg_addr_reg;
                                bit_index_next = 4'd0;
                                phase_next     = PH_TX_SET;
                            end
                            2'd1:
                            begin
                                byte_step_next = 2'd2;
                                if (is_read_reg)
                                begin
                                    phase_next = PH_ST_HI;
                                end
                                else
                                begin
                                    shift_next     = wr_data_reg;
                                    bit_index_next = 4'd0;
                                    phase_next     = PH_TX_SET;
                                end
                            end
                            default:
                            begin
                                if (is_read_reg)
                                begin
                                    shift_next      = 8'd0;
                                    bit_index_next  = 4'd0;
                                    poll_count_next = 8'd0;
                                    phase_next      = (read_pause_reg != 8'd0) ? PH_PAUSE
                                                                                : PH_RX_LO;
                                end
                                else
                                begin
                                    phase_next = PH_SP_LO;
                                end
                            end
                        endcase
                    end
                    else if (poll_count_reg >= ack_timeout_reg)
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_SP_LO;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                    end
                end
                PH_PAUSE:
                    if (elapsed)
                    begin
                        poll_count_next = poll_inc;
                        if (poll_inc >= read_pause_reg) phase_next = PH_RX_LO;
                    end
                PH_RX_LO:
                    if (elapsed) phase_next = PH_RX_HI;
                PH_RX_HI:
                    if (elapsed)
                    begin
                        shift_next = rx_shift;
                        if (bit_inc >= 4'd8)
                        begin
                            bit_index_next = 4'd0;
                            last_read_next = rx_shift;
                            phase_next     = PH_NAK_LO;
                        end
                        else
                        begin
                            bit_index_next = bit_inc;
                            phase_next     = PH_RX_LO;
                        end
                    end
                PH_NAK_LO:
                    if (elapsed) phase_next = PH_NAK_HI;
                PH_NAK_HI:
                    if (elapsed) phase_next = PH_SP_LO;
                PH_SP_LO:
                    if (elapsed) phase_next = PH_SP_HI;
                PH_SP_HI:
                    if (elapsed)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                default:
                begin
                    phase_next       = PH_IDLE;
                    delay_count_next = 16'd0;
                end
            endcase
        end
    end

    // pin levels after this step
    always_comb
    begin
        rsp.busy_res  = (phase_next != PH_IDLE);
        rsp.done_res  = done;
        rsp.read_data = last_read_next;
        rsp.ack_error = err_next;
        case (phase_next)
            PH_ST_LO:
            begin
                rsp.scl = 1'b1; rsp.sda_out = 1'b0; rsp.sda_drive = 1'b1;
            end
            PH_TX_SET, PH_TX_LO:
            begin
                rsp.scl = 1'b0; rsp.sda_out = shift_next[7]; rsp.sda_drive = 1'b1;
            end
            PH_TX_HI:
            begin
                rsp.scl = 1'b1; rsp.sda_out = shift_next[7]; rsp.sda_drive = 1'b1;
            end
            PH_ACK_REL, PH_PAUSE, PH_RX_LO:
            begin
                rsp.scl = 1'b0; rsp.sda_out = 1'b1; rsp.sda_drive = 1'b0;
            end
            PH_ACK_HI, PH_ACK_POLL, PH_RX_HI:
            begin
                rsp.scl = 1'b1; rsp.sda_out = 1'b1; rsp.sda_drive = 1'b0;
            end
            PH_NAK_LO:
            begin
                rsp.scl = 1'b0; rsp.sda_out = 1'b1; rsp.sda_drive = 1'b1;
            end
            PH_SP_LO:
            begin
                rsp.scl = 1'b0; rsp.sda_out = 1'b0; rsp.sda_drive = 1'b1;
            end
            default:
            begin
                rsp.scl = 1'b1; rsp.sda_out = 1'b1; rsp.sda_drive = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_unit_reg  <= i2cm_pkg::DELAY_UNIT_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
            read_pause_reg  <= i2cm_pkg::READ_PAUSE_RST;
            phase_reg       <= PH_IDLE;
            byte_step_reg   <= 2'd0;
            bit_index_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            delay_count_reg <= 16'd0;
            poll_count_reg  <= 8'd0;
            dev_addr_reg    <= 7'd0;
            reg_addr_reg    <= 8'd0;
            wr_data_reg     <= 8'd0;
            is_read_reg     <= 1'b0;
            last_read_reg   <= 8'd0;
            err_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    i2cm_pkg::CFG_DELAY_UNIT:  delay_unit_reg  <= cfg_data;
                    i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                    i2cm_pkg::CFG_READ_PAUSE:  read_pause_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (fire)
            begin
                phase_reg       <= phase_next;
                byte_step_reg   <= byte_step_next;
                bit_index_reg   <= bit_index_next;
                shift_reg       <= shift_next;
                delay_count_reg <= delay_count_next;
                poll_count_reg  <= poll_count_next;
                dev_addr_reg    <= dev_addr_next;
                reg_addr_reg    <= reg_addr_next;
                wr_data_reg     <= wr_data_next;
                is_read_reg     <= is_read_next;
                last_read_reg   <= last_read_next;
                err_reg         <= err_next;
            end
        end
    end

endmodule

### rtl/core/i2cm_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_rsp_queue
// Two-entry result queue between the engine and the pop side.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module i2cm_rsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rsp_push,
    input  i2cm_pkg::result_t rsp,
    output logic              rsp_full,
    output logic              empty,
    input  logic              pop,
    output i2cm_pkg::result_t result
);

    i2cm_pkg::result_t mem_reg [i2cm_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign rsp_full = (count_reg == 2'(i2cm_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign do_push  = rsp_push && !rsp_full;
    assign do_pop   = pop && !empty;
    assign result   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= rsp;
        end
    end

endmodule
